[hdl/crtu_pkg.sv]
// Package for the CPU register transfer unit.
// Holds opcodes, decoded item types, flag masks and reset values.
// No dependencies.
package crtu_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [5:0] OP_XBA = 6'd1;
  localparam logic [5:0] OP_XCE = 6'd2;
  localparam logic [5:0] OP_CLC = 6'd3;
  localparam logic [5:0] OP_CLD = 6'd4;
  localparam logic [5:0] OP_CLI = 6'd5;
  localparam logic [5:0] OP_CLV = 6'd6;
  localparam logic [5:0] OP_SEC = 6'd7;
  localparam logic [5:0] OP_SED = 6'd8;
  localparam logic [5:0] OP_SEI = 6'd9;
  localparam logic [5:0] OP_REP = 6'd10;
  localparam logic [5:0] OP_SEP = 6'd11;
  localparam logic [5:0] OP_TAX = 6'd12;
  localparam logic [5:0] OP_TAY = 6'd13;
  localparam logic [5:0] OP_TXA = 6'd14;
  localparam logic [5:0] OP_TXY = 6'd15;
  localparam logic [5:0] OP_TYA = 6'd16;
  localparam logic [5:0] OP_TYX = 6'd17;
  localparam logic [5:0] OP_TCD = 6'd18;
  localparam logic [5:0] OP_TCS = 6'd19;
  localparam logic [5:0] OP_TDC = 6'd20;
  localparam logic [5:0] OP_TSC = 6'd21;
  localparam logic [5:0] OP_TSX = 6'd22;
  localparam logic [5:0] OP_TXS = 6'd23;
  localparam logic [5:0] OP_PHA = 6'd24;
  localparam logic [5:0] OP_PHX = 6'd25;
  localparam logic [5:0] OP_PHY = 6'd26;
  localparam logic [5:0] OP_PHD = 6'd27;
  localparam logic [5:0] OP_PHB = 6'd28;
  localparam logic [5:0] OP_PHP = 6'd29;
  localparam logic [5:0] OP_PLA = 6'd30;
  localparam logic [5:0] OP_PLX = 6'd31;
  localparam logic [5:0] OP_PLY = 6'd32;
  localparam logic [5:0] OP_PLD = 6'd33;
  localparam logic [5:0] OP_PLB = 6'd34;
  localparam logic [5:0] OP_PLP = 6'd35;

  localparam logic [7:0] FLAG_V      = 8'h40;
  localparam logic [7:0] FLAG_D      = 8'h08;
  localparam logic [7:0] FLAG_I      = 8'h04;
  localparam logic [7:0] FLAG_C      = 8'h01;
  localparam logic [7:0] WIDTH_FLAGS = 8'h30;
  localparam int unsigned BIT_N = 7;
  localparam int unsigned BIT_M = 5;
  localparam int unsigned BIT_X = 4;
  localparam int unsigned BIT_Z = 1;
  localparam int unsigned BIT_C = 0;

  localparam logic [7:0]  STACK_PAGE = 8'h01;
  localparam logic [15:0] SP_RESET   = 16'h01FF;
  localparam logic [7:0]  P_RESET    = 8'h34;

  typedef enum logic [3:0] {
    K_NOP,
    K_XBA,
    K_XCE,
    K_CLR,
    K_SET,
    K_REP,
    K_SEP,
    K_XFER,
    K_PUSH,
    K_PULL
  } kind_e;

  typedef enum logic [2:0] {
    R_A,
    R_X,
    R_Y,
    R_D,
    R_S,
    R_B,
    R_P
  } reg_e;

  typedef struct packed {
    kind_e       kind;
    reg_e        src;
    reg_e        dst;
    logic        wide;
    logic [7:0]  mask;
    logic [15:0] pull;
  } item_t;

endpackage

[hdl/crtu_front.sv]
// Front end of the CPU register transfer unit.
// Accepts instructions and classifies them into decoded items.
// Depends on crtu_pkg.
module crtu_front (
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [5:0]        operation_i,
  input  logic [7:0]        mask_byte_i,
  input  logic [15:0]       pull_data_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output crtu_pkg::item_t   q_item_o
);

  crtu_pkg::item_t item;

  always_comb begin
    item      = '0;
    item.kind = crtu_pkg::K_NOP;
    item.src  = crtu_pkg::R_A;
    item.dst  = crtu_pkg::R_A;
    item.wide = 1'b0;
    item.mask = 8'h00;
    item.pull = pull_data_i;
    case (operation_i)
      crtu_pkg::OP_XBA: item.kind = crtu_pkg::K_XBA;
      crtu_pkg::OP_XCE: item.kind = crtu_pkg::K_XCE;
      crtu_pkg::OP_CLC: begin
        item.kind = crtu_pkg::K_CLR;
        item.mask = crtu_pkg::FLAG_C;
      end
      crtu_pkg::OP_CLD: begin
        item.kind = crtu_pkg::K_CLR;
        item.mask = crtu_pkg::FLAG_D;
      end
      crtu_pkg::OP_CLI: begin
        item.kind = crtu_pkg::K_CLR;
        item.mask = crtu_pkg::FLAG_I;
      end
      crtu_pkg::OP_CLV: begin
        item.kind = crtu_pkg::K_CLR;
        item.mask = crtu_pkg::FLAG_V;
      end
      crtu_pkg::OP_SEC: begin
        item.kind = crtu_pkg::K_SET;
        item.mask = crtu_pkg::FLAG_C;
      end
      crtu_pkg::OP_SED: begin
        item.kind = crtu_pkg::K_SET;
        item.mask = crtu_pkg::FLAG_D;
      end
      crtu_pkg::OP_SEI: begin
        item.kind = crtu_pkg::K_SET;
        item.mask = crtu_pkg::FLAG_I;
      end
      crtu_pkg::OP_REP: begin
        item.kind = crtu_pkg::K_REP;
        item.mask = mask_byte_i;
      end
      crtu_pkg::OP_SEP: begin
        item.kind = crtu_pkg::K_SEP;
        item.mask = mask_byte_i;
      end
      crtu_pkg::OP_TAX: begin
        item.kind = crtu_pkg::K_XFER;
        item.src  = crtu_pkg::R_A;
        item.dst  = crtu_pkg::R_X;
      end
      crtu_pkg::OP_TAY: begin
        item.kind = crtu_pkg::K_XFER;
        item.src  = crtu_pkg::R_A;
        item.dst  = crtu_pkg::R_Y;
      end
      crtu_pkg::OP_TXA: begin
        item.kind = crtu_pkg::K_XFER;
        item.src  = crtu_pkg::R_X;
        item.dst  = crtu_pkg::R_A;
      end
      crtu_pkg::OP_TXY: begin
        item.kind = crtu_pkg::K_XFER;
        item.src  = crtu_pkg::R_X;
        item.dst  = crtu_pkg::R_Y;
      end
      crtu_pkg::OP_TYA: begin
        item.kind = crtu_pkg::K_XFER;
        item.src  = crtu_pkg::R_Y;
        item.dst  = crtu_pkg::R_A;
      end
      crtu_pkg::OP_TYX: begin
        item.kind = crtu_pkg::K_XFER;
        item.src  = crtu_pkg::R_Y;
        item.dst  = crtu_pkg::R_X;
      end
      crtu_pkg::OP_TCD: begin
        item.kind = crtu_pkg::K_XFER;
        item.src  = crtu_pkg::R_A;
        item.dst  = crtu_pkg::R_D;
      end
      crtu_pkg::OP_TCS: begin
        item.kind = crtu_pkg::K_XFER;
        item.src  = crtu_pkg::R_A;
        item.dst  = crtu_pkg::R_S;
      end
      crtu_pkg::OP_TDC: begin
        item.kind = crtu_pkg::K_XFER;
        item.src  = crtu_pkg::R_D;
        item.dst  = crtu_pkg::R_A;
        item.wide = 1'b1;
      end
      crtu_pkg::OP_TSC: begin
        item.kind = crtu_pkg::K_XFER;
        item.src  = crtu_pkg::R_S;
        item.dst  = crtu_pkg::R_A;
        item.wide = 1'b1;
      end
      crtu_pkg::OP_TSX: begin
        item.kind = crtu_pkg::K_XFER;
        item.src  = crtu_pkg::R_S;
        item.dst  = crtu_pkg::R_X;
      end
      crtu_pkg::OP_TXS: begin
        item.kind = crtu_pkg::K_XFER;
        item.src  = crtu_pkg::R_X;
        item.dst  = crtu_pkg::R_S;
      end
      crtu_pkg::OP_PHA: begin
        item.kind = crtu_pkg::K_PUSH;
        item.src  = crtu_pkg::R_A;
      end
      crtu_pkg::OP_PHX: begin
        item.kind = crtu_pkg::K_PUSH;
        item.src  = crtu_pkg::R_X;
      end
      crtu_pkg::OP_PHY: begin
        item.kind = crtu_pkg::K_PUSH;
        item.src  = crtu_pkg::R_Y;
      end
      crtu_pkg::OP_PHD: begin
        item.kind = crtu_pkg::K_PUSH;
        item.src  = crtu_pkg::R_D;
      end
      crtu_pkg::OP_PHB: begin
        item.kind = crtu_pkg::K_PUSH;
        item.src  = crtu_pkg::R_B;
      end
      crtu_pkg::OP_PHP: begin
        item.kind = crtu_pkg::K_PUSH;
        item.src  = crtu_pkg::R_P;
      end
      crtu_pkg::OP_PLA: begin
        item.kind = crtu_pkg::K_PULL;
        item.dst  = crtu_pkg::R_A;
      end
      crtu_pkg::OP_PLX: begin
        item.kind = crtu_pkg::K_PULL;
        item.dst  = crtu_pkg::R_X;
      end
      crtu_pkg::OP_PLY: begin
        item.kind = crtu_pkg::K_PULL;
        item.dst  = crtu_pkg::R_Y;
      end
      crtu_pkg::OP_PLD: begin
        item.kind = crtu_pkg::K_PULL;
        item.dst  = crtu_pkg::R_D;
      end
      crtu_pkg::OP_PLB: begin
        item.kind = crtu_pkg::K_PULL;
        item.dst  = crtu_pkg::R_B;
      end
      crtu_pkg::OP_PLP: begin
        item.kind = crtu_pkg::K_PULL;
        item.dst  = crtu_pkg::R_P;
      end
      default: item.kind = crtu_pkg::K_NOP;
    endcase
  end

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i & ~q_full_i;
  assign q_item_o   = item;

endmodule

[hdl/crtu_queue.sv]
// Decoded item queue between front and back of the register transfer unit.
// Small register FIFO; stalls the front only when full.
// Depends on crtu_pkg.
module crtu_queue #(
  parameter int unsigned Depth = crtu_pkg::QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  crtu_pkg::item_t   item_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output crtu_pkg::item_t   item_o
);

  localparam int unsigned IdxW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  crtu_pkg::item_t  mem_q [Depth];
  logic [IdxW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [IdxW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_pop;

  assign full_o  = (count_q == FullCnt);
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastIdx) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastIdx) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

[hdl/crtu_back.sv]
// Back end of the register transfer unit: register file and execution.
// Executes one decoded item per cycle while its output is not stalled, and holds the result registers.
// Depends on crtu_pkg.
module crtu_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  crtu_pkg::item_t   q_item_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [15:0]       acc_out_o,
  output logic [15:0]       x_out_o,
  output logic [15:0]       y_out_o,
  output logic [15:0]       direct_out_o,
  output logic [15:0]       sp_out_o,
  output logic [7:0]        bank_out_o,
  output logic [7:0]        status_out_o,
  output logic              emulation_out_o,
  output logic [15:0]       push_data_o,
  output logic [1:0]        push_count_o
);

  logic [15:0] a_q, a_d, x_q, x_d, y_q, y_d, d_q, d_d, s_q, s_d;
  logic [7:0]  b_q, b_d, p_q, p_d;
  logic        e_q, e_d;
  logic [15:0] push_q, push_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        out_valid_q, out_valid_d;
  logic        fire;

  logic        m8, x8;
  logic [15:0] src_val, dst_old, res;
  logic        src_narrow, dst_narrow;
  logic        nz_en, nz_narrow, fix;
  logic [15:0] nz_val;
  logic [1:0]  step;

  function automatic logic [15:0] reg_val(crtu_pkg::reg_e r, logic [15:0] a, logic [15:0] x,
                                          logic [15:0] y, logic [15:0] d, logic [15:0] s,
                                          logic [7:0] b, logic [7:0] p);
    logic [15:0] v;
    case (r)
      crtu_pkg::R_A: v = a;
      crtu_pkg::R_X: v = x;
      crtu_pkg::R_Y: v = y;
      crtu_pkg::R_D: v = d;
      crtu_pkg::R_S: v = s;
      crtu_pkg::R_B: v = {8'h00, b};
      crtu_pkg::R_P: v = {8'h00, p};
      default:       v = '0;
    endcase
    return v;
  endfunction

  function automatic logic is_narrow(crtu_pkg::reg_e r, logic m, logic x, logic wide);
    logic n;
    case (r)
      crtu_pkg::R_A: n = m & ~wide;
      crtu_pkg::R_X: n = x;
      crtu_pkg::R_Y: n = x;
      crtu_pkg::R_B: n = 1'b1;
      crtu_pkg::R_P: n = 1'b1;
      default:       n = 1'b0;
    endcase
    return n;
  endfunction

  assign fire    = q_valid_i & (~out_valid_q | ~out_stall_i);
  assign q_pop_o = fire;
  assign m8      = p_q[crtu_pkg::BIT_M];
  assign x8      = p_q[crtu_pkg::BIT_X];

  always_comb begin
    src_val    = reg_val(q_item_i.src, a_q, x_q, y_q, d_q, s_q, b_q, p_q);
    dst_old    = reg_val(q_item_i.dst, a_q, x_q, y_q, d_q, s_q, b_q, p_q);
    src_narrow = is_narrow(q_item_i.src, m8, x8, 1'b0);
    dst_narrow = is_narrow(q_item_i.dst, m8, x8, q_item_i.wide);
    step       = 2'd0;
    res        = '0;
    a_d        = a_q;
    x_d        = x_q;
    y_d        = y_q;
    d_d        = d_q;
    s_d        = s_q;
    b_d        = b_q;
    p_d        = p_q;
    e_d        = e_q;
    push_d     = '0;
    cnt_d      = 2'd0;
    nz_en      = 1'b0;
    nz_narrow  = 1'b0;
    nz_val     = '0;
    fix        = 1'b0;

    case (q_item_i.kind)
      crtu_pkg::K_XBA: begin
        a_d       = {a_q[7:0], a_q[15:8]};
        nz_en     = 1'b1;
        nz_narrow = 1'b1;
        nz_val    = {a_q[7:0], a_q[15:8]};
      end
      crtu_pkg::K_XCE: begin
        p_d[crtu_pkg::BIT_C] = e_q;
        e_d = p_q[crtu_pkg::BIT_C];
        if (p_q[crtu_pkg::BIT_C]) begin
          s_d = {crtu_pkg::STACK_PAGE, s_q[7:0]};
        end
        fix = 1'b1;
      end
      crtu_pkg::K_CLR: p_d = p_q & ~q_item_i.mask;
      crtu_pkg::K_SET: p_d = p_q | q_item_i.mask;
      crtu_pkg::K_REP: begin
        p_d = p_q & ~q_item_i.mask;
        fix = 1'b1;
      end
      crtu_pkg::K_SEP: begin
        p_d = p_q | q_item_i.mask;
        fix = 1'b1;
      end
      crtu_pkg::K_XFER: begin
        if (q_item_i.dst == crtu_pkg::R_S) begin
          if (!e_q) begin
            s_d = src_val;
          end else if (q_item_i.src == crtu_pkg::R_A) begin
            s_d = {crtu_pkg::STACK_PAGE, src_val[7:0]};
          end else begin
            s_d = {s_q[15:8], src_val[7:0]};
          end
        end else begin
          res       = dst_narrow ? {dst_old[15:8], src_val[7:0]} : src_val;
          nz_en     = 1'b1;
          nz_narrow = dst_narrow;
          nz_val    = res;
        end
      end
      crtu_pkg::K_PUSH: begin
        step   = src_narrow ? 2'd1 : 2'd2;
        cnt_d  = step;
        push_d = src_narrow ? {8'h00, src_val[7:0]} : src_val;
        s_d    = e_q ? {crtu_pkg::STACK_PAGE, s_q[7:0] - {6'd0, step}}
                     : s_q - {14'd0, step};
      end
      crtu_pkg::K_PULL: begin
        step = dst_narrow ? 2'd1 : 2'd2;
        s_d  = e_q ? {crtu_pkg::STACK_PAGE, s_q[7:0] + {6'd0, step}}
                   : s_q + {14'd0, step};
        res  = dst_narrow ? {dst_old[15:8], q_item_i.pull[7:0]} : q_item_i.pull;
        if (q_item_i.dst == crtu_pkg::R_P) begin
          fix = 1'b1;
        end else begin
          nz_en     = 1'b1;
          nz_narrow = dst_narrow;
          nz_val    = res;
        end
      end
      default: ;
    endcase

    if (q_item_i.kind == crtu_pkg::K_XFER || q_item_i.kind == crtu_pkg::K_PULL) begin
      case (q_item_i.dst)
        crtu_pkg::R_A: a_d = res;
        crtu_pkg::R_X: x_d = res;
        crtu_pkg::R_Y: y_d = res;
        crtu_pkg::R_D: d_d = res;
        crtu_pkg::R_B: b_d = res[7:0];
        crtu_pkg::R_P: p_d = res[7:0];
        default: ;
      endcase
    end

    if (nz_en) begin
      p_d[crtu_pkg::BIT_N] = nz_narrow ? nz_val[7] : nz_val[15];
      p_d[crtu_pkg::BIT_Z] = nz_narrow ? (nz_val[7:0] == 8'h00) : (nz_val == 16'h0000);
    end

    if (fix) begin
      if (e_d) begin
        p_d = p_d | crtu_pkg::WIDTH_FLAGS;
      end
      if (p_d[crtu_pkg::BIT_X]) begin
        x_d[15:8] = 8'h00;
        y_d[15:8] = 8'h00;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q & out_stall_i;
    if (fire) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q         <= '0;
      x_q         <= '0;
      y_q         <= '0;
      d_q         <= '0;
      s_q         <= crtu_pkg::SP_RESET;
      b_q         <= '0;
      p_q         <= crtu_pkg::P_RESET;
      e_q         <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (fire) begin
        a_q <= a_d;
        x_q <= x_d;
        y_q <= y_d;
        d_q <= d_d;
        s_q <= s_d;
        b_q <= b_d;
        p_q <= p_d;
        e_q <= e_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      push_q <= push_d;
      cnt_q  <= cnt_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign acc_out_o       = a_q;
  assign x_out_o         = x_q;
  assign y_out_o         = y_q;
  assign direct_out_o    = d_q;
  assign sp_out_o        = s_q;
  assign bank_out_o      = b_q;
  assign status_out_o    = p_q;
  assign emulation_out_o = e_q;
  assign push_data_o     = push_q;
  assign push_count_o    = cnt_q;

endmodule

[hdl/cpu_register_transfer_unit.sv]
// CPU register transfer unit, top level.
// Sustains one instruction per clock while the output is not stalled: the
// front decodes an accepted instruction into a small queue, and the back
// executes it against its register file (A, X, Y, D, S, data bank,
// status, emulation bit) and registers the result.
// The back's execute step sets the rate. The queue lets the front keep
// taking instructions, until it is full, while a result waits on a stalled output.
// Depends on crtu_pkg, crtu_front, crtu_queue and crtu_back.
module cpu_register_transfer_unit #(
  parameter int unsigned QueueDepth = crtu_pkg::QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [5:0]  operation_i,
  input  logic [7:0]  mask_byte_i,
  input  logic [15:0] pull_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] acc_out_o,
  output logic [15:0] x_out_o,
  output logic [15:0] y_out_o,
  output logic [15:0] direct_out_o,
  output logic [15:0] sp_out_o,
  output logic [7:0]  bank_out_o,
  output logic [7:0]  status_out_o,
  output logic        emulation_out_o,
  output logic [15:0] push_data_o,
  output logic [1:0]  push_count_o
);

  logic            q_full, q_push, q_valid, q_pop;
  crtu_pkg::item_t front_item, back_item;

  crtu_front u_front (
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .mask_byte_i (mask_byte_i),
    .pull_data_i (pull_data_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_item_o    (front_item)
  );

  crtu_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (front_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (back_item)
  );

  crtu_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_item_i        (back_item),
    .q_pop_o         (q_pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .acc_out_o       (acc_out_o),
    .x_out_o         (x_out_o),
    .y_out_o         (y_out_o),
    .direct_out_o    (direct_out_o),
    .sp_out_o        (sp_out_o),
    .bank_out_o      (bank_out_o),
    .status_out_o    (status_out_o),
    .emulation_out_o (emulation_out_o),
    .push_data_o     (push_data_o),
    .push_count_o    (push_count_o)
  );

endmodule

[sim/testbench.sv]
// Self-checking testbench for cpu_register_transfer_unit.
// Runs directed and random instructions through the block and compares each
// result against an internal register-file model. Depends on crtu_pkg.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [5:0] OP_NOP = 6'd0;
  localparam logic [5:0] OP_LAST_UNUSED = 6'd63;
  localparam int unsigned QUIET_TAIL = 60;

  typedef struct packed {
    logic [5:0]  op;
    logic [7:0]  mask;
    logic [15:0] pull;
  } instr_t;

  typedef struct packed {
    logic [15:0] a;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] d;
    logic [15:0] s;
    logic [7:0]  b;
    logic [7:0]  p;
    logic        e;
    logic [15:0] pushed;
    logic [1:0]  count;
  } regfile_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid;
  logic        in_stall;
  logic [5:0]  operation;
  logic [7:0]  mask_byte;
  logic [15:0] pull_data;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] acc_out;
  logic [15:0] x_out;
  logic [15:0] y_out;
  logic [15:0] direct_out;
  logic [15:0] sp_out;
  logic [7:0]  bank_out;
  logic [7:0]  status_out;
  logic        emulation_out;
  logic [15:0] push_data;
  logic [1:0]  push_count;

  cpu_register_transfer_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .operation_i     (operation),
    .mask_byte_i     (mask_byte),
    .pull_data_i     (pull_data),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .acc_out_o       (acc_out),
    .x_out_o         (x_out),
    .y_out_o         (y_out),
    .direct_out_o    (direct_out),
    .sp_out_o        (sp_out),
    .bank_out_o      (bank_out),
    .status_out_o    (status_out),
    .emulation_out_o (emulation_out),
    .push_data_o     (push_data),
    .push_count_o    (push_count)
  );

  // CPU register file model
  logic [15:0] cpu_a, cpu_x, cpu_y, cpu_d, cpu_s;
  logic [7:0]  cpu_b, cpu_p;
  logic        cpu_e;

  instr_t      pending_q[$];
  regfile_t    expected_q[$];
  int unsigned errors;
  int unsigned accepted;
  int unsigned total_items;
  int unsigned send_gap;
  int unsigned stall_gap;
  instr_t      next_instr;
  bit          take;
  regfile_t    got;
  regfile_t    want;

  function automatic void set_nz(logic [15:0] v, bit wide);
    cpu_p[crtu_pkg::BIT_N] = wide ? v[15] : v[7];
    cpu_p[crtu_pkg::BIT_Z] = wide ? (v == 16'h0000) : (v[7:0] == 8'h00);
  endfunction

  function automatic void fix_modes();
    if (cpu_e) cpu_p = cpu_p | crtu_pkg::WIDTH_FLAGS;
    if (cpu_p[crtu_pkg::BIT_X]) begin
      cpu_x[15:8] = 8'h00;
      cpu_y[15:8] = 8'h00;
    end
  endfunction

  function automatic void bump_sp(logic [15:0] delta);
    if (cpu_e) cpu_s = {crtu_pkg::STACK_PAGE, 8'(cpu_s[7:0] + delta[7:0])};
    else cpu_s = cpu_s + delta;
  endfunction

  function automatic void page_one();
    if (cpu_e) cpu_s[15:8] = crtu_pkg::STACK_PAGE;
  endfunction

  function automatic logic [15:0] moved(logic [15:0] dst, logic [15:0] src, bit narrow);
    logic [15:0] r;
    r = narrow ? {dst[15:8], src[7:0]} : src;
    set_nz(r, !narrow);
    return r;
  endfunction

  function automatic logic [15:0] pulled(logic [15:0] dst, logic [15:0] data, bit narrow);
    bump_sp(16'h0001);
    if (!narrow) bump_sp(16'h0001);
    return moved(dst, data, narrow);
  endfunction

  function automatic regfile_t execute(instr_t it);
    regfile_t r;
    bit m8;
    bit x8;
    bit narrow;
    logic [15:0] v;
    logic carry;
    m8 = cpu_p[crtu_pkg::BIT_M];
    x8 = cpu_p[crtu_pkg::BIT_X];
    r.pushed = 16'h0000;
    r.count = 2'd0;
    case (it.op)
      crtu_pkg::OP_XBA: begin
        cpu_a = {cpu_a[7:0], cpu_a[15:8]};
        set_nz(cpu_a, 1'b0);
      end
      crtu_pkg::OP_XCE: begin
        carry = cpu_p[crtu_pkg::BIT_C];
        cpu_p[crtu_pkg::BIT_C] = cpu_e;
        cpu_e = carry;
        page_one();
        fix_modes();
      end
      crtu_pkg::OP_CLC: cpu_p = cpu_p & ~crtu_pkg::FLAG_C;
      crtu_pkg::OP_CLD: cpu_p = cpu_p & ~crtu_pkg::FLAG_D;
      crtu_pkg::OP_CLI: cpu_p = cpu_p & ~crtu_pkg::FLAG_I;
      crtu_pkg::OP_CLV: cpu_p = cpu_p & ~crtu_pkg::FLAG_V;
      crtu_pkg::OP_SEC: cpu_p = cpu_p | crtu_pkg::FLAG_C;
      crtu_pkg::OP_SED: cpu_p = cpu_p | crtu_pkg::FLAG_D;
      crtu_pkg::OP_SEI: cpu_p = cpu_p | crtu_pkg::FLAG_I;
      crtu_pkg::OP_REP: begin
        cpu_p = cpu_p & ~it.mask;
        fix_modes();
      end
      crtu_pkg::OP_SEP: begin
        cpu_p = cpu_p | it.mask;
        fix_modes();
      end
      crtu_pkg::OP_TAX: cpu_x = moved(cpu_x, cpu_a, x8);
      crtu_pkg::OP_TAY: cpu_y = moved(cpu_y, cpu_a, x8);
      crtu_pkg::OP_TXA: cpu_a = moved(cpu_a, cpu_x, m8);
      crtu_pkg::OP_TXY: cpu_y = moved(cpu_y, cpu_x, x8);
      crtu_pkg::OP_TYA: cpu_a = moved(cpu_a, cpu_y, m8);
      crtu_pkg::OP_TYX: cpu_x = moved(cpu_x, cpu_y, x8);
      crtu_pkg::OP_TCD: cpu_d = moved(cpu_d, cpu_a, 1'b0);
      crtu_pkg::OP_TCS: begin
        cpu_s = cpu_a;
        page_one();
      end
      crtu_pkg::OP_TDC: cpu_a = moved(cpu_a, cpu_d, 1'b0);
      crtu_pkg::OP_TSC: cpu_a = moved(cpu_a, cpu_s, 1'b0);
      crtu_pkg::OP_TSX: cpu_x = moved(cpu_x, cpu_s, x8);
      crtu_pkg::OP_TXS: cpu_s = cpu_e ? {cpu_s[15:8], cpu_x[7:0]} : cpu_x;
      crtu_pkg::OP_PHA, crtu_pkg::OP_PHX, crtu_pkg::OP_PHY: begin
        v = (it.op == crtu_pkg::OP_PHA) ? cpu_a : (it.op == crtu_pkg::OP_PHX) ? cpu_x : cpu_y;
        narrow = (it.op == crtu_pkg::OP_PHA) ? m8 : x8;
        if (narrow) begin
          r.pushed = {8'h00, v[7:0]};
          r.count = 2'd1;
          bump_sp(16'hFFFF);
        end else begin
          r.pushed = v;
          r.count = 2'd2;
          bump_sp(16'hFFFF);
          bump_sp(16'hFFFF);
        end
      end
      crtu_pkg::OP_PHD: begin
        r.pushed = cpu_d;
        r.count = 2'd2;
        cpu_s = cpu_s - 16'd2;
        page_one();
      end
      crtu_pkg::OP_PHB: begin
        r.pushed = {8'h00, cpu_b};
        r.count = 2'd1;
        bump_sp(16'hFFFF);
      end
      crtu_pkg::OP_PHP: begin
        r.pushed = {8'h00, cpu_p};
        r.count = 2'd1;
        bump_sp(16'hFFFF);
      end
      crtu_pkg::OP_PLA: cpu_a = pulled(cpu_a, it.pull, m8);
      crtu_pkg::OP_PLX: cpu_x = pulled(cpu_x, it.pull, x8);
      crtu_pkg::OP_PLY: cpu_y = pulled(cpu_y, it.pull, x8);
      crtu_pkg::OP_PLD: begin
        cpu_s = cpu_s + 16'd2;
        cpu_d = it.pull;
        set_nz(cpu_d, 1'b1);
        page_one();
      end
      crtu_pkg::OP_PLB: begin
        bump_sp(16'h0001);
        cpu_b = it.pull[7:0];
        set_nz({8'h00, cpu_b}, 1'b0);
      end
      crtu_pkg::OP_PLP: begin
        bump_sp(16'h0001);
        cpu_p = it.pull[7:0];
        fix_modes();
      end
      default: ;
    endcase
    r.a = cpu_a;
    r.x = cpu_x;
    r.y = cpu_y;
    r.d = cpu_d;
    r.s = cpu_s;
    r.b = cpu_b;
    r.p = cpu_p;
    r.e = cpu_e;
    return r;
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch: %s", what);
    errors++;
  endtask

  task automatic check_field(string name, logic [15:0] seen, logic [15:0] wanted);
    if (seen !== wanted) begin
      report_mismatch($sformatf("%s got %h, want %h", name, seen, wanted));
    end
  endtask

  function automatic void queue_instr(logic [5:0] op, logic [7:0] mask, logic [15:0] pull);
    instr_t it;
    it.op = op;
    it.mask = mask;
    it.pull = pull;
    pending_q.push_back(it);
  endfunction

  function automatic instr_t random_instr();
    instr_t it;
    int unsigned r;
    logic [15:0] corner[6];
    corner = '{16'h0000, 16'hFFFF, 16'h8000, 16'h0080, 16'h00FF, 16'hFF00};
    r = $urandom_range(0, 99);
    if (r < 6) it.op = 6'($urandom_range(36, 63));
    else if (r < 8) it.op = OP_NOP;
    else if (r < 18) begin
      case ($urandom_range(0, 3))
        0: it.op = crtu_pkg::OP_XCE;
        1: it.op = crtu_pkg::OP_REP;
        2: it.op = crtu_pkg::OP_SEP;
        default: it.op = crtu_pkg::OP_CLC;
      endcase
    end else it.op = 6'($urandom_range(1, 35));
    it.mask = 8'($urandom);
    if ($urandom_range(0, 7) == 0) it.pull = corner[$urandom_range(0, 5)];
    else it.pull = 16'($urandom);
    return it;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2ms;
    $display("Some tests failed");
    $finish;
  end

  // Driver: advance to the next pending transaction once the current one is taken, with random idle gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      operation <= OP_NOP;
      mask_byte <= 8'h00;
      pull_data <= 16'h0000;
      send_gap = 0;
      cpu_a = 16'h0000;
      cpu_x = 16'h0000;
      cpu_y = 16'h0000;
      cpu_d = 16'h0000;
      cpu_s = crtu_pkg::SP_RESET;
      cpu_b = 8'h00;
      cpu_p = crtu_pkg::P_RESET;
      cpu_e = 1'b1;
    end else begin
      take = in_valid && !in_stall;
      if (take) begin
        expected_q.push_back(execute('{operation, mask_byte, pull_data}));
        accepted++;
      end
      if (!in_valid || take) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_q.size() > QUIET_TAIL && $urandom_range(0, 7) == 0) begin
          send_gap = $urandom_range(1, 19) - 1;
          in_valid <= 1'b0;
        end else if (pending_q.size() != 0) begin
          next_instr = pending_q.pop_front();
          operation <= next_instr.op;
          mask_byte <= next_instr.mask;
          pull_data <= next_instr.pull;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall in random bursts, none near the end
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
      stall_gap = 0;
    end else if (stall_gap != 0) begin
      stall_gap--;
      out_stall <= 1'b1;
    end else if (pending_q.size() > QUIET_TAIL && $urandom_range(0, 7) == 0) begin
      stall_gap = $urandom_range(1, 19) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitor: compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      got = '{acc_out, x_out, y_out, direct_out, sp_out, bank_out, status_out,
              emulation_out, push_data, push_count};
      if (expected_q.size() == 0) begin
        report_mismatch("result with no pending transaction");
      end else begin
        want = expected_q.pop_front();
        check_field("acc_out", got.a, want.a);
        check_field("x_out", got.x, want.x);
        check_field("y_out", got.y, want.y);
        check_field("direct_out", got.d, want.d);
        check_field("sp_out", got.s, want.s);
        check_field("bank_out", {8'h00, got.b}, {8'h00, want.b});
        check_field("status_out", {8'h00, got.p}, {8'h00, want.p});
        check_field("emulation_out", {15'h0, got.e}, {15'h0, want.e});
        check_field("push_data", got.pushed, want.pushed);
        check_field("push_count", {14'h0, got.count}, {14'h0, want.count});
      end
    end
  end

  initial begin
    rst_ni = 1'b0;

    queue_instr(OP_NOP, 8'h00, 16'h0000);
    queue_instr(crtu_pkg::OP_XBA, 8'h00, 16'h0000);
    queue_instr(crtu_pkg::OP_TSC, 8'h00, 16'h0000);
    queue_instr(crtu_pkg::OP_PLA, 8'h00, 16'hFF80);
    queue_instr(crtu_pkg::OP_PHP, 8'h00, 16'h0000);
    queue_instr(crtu_pkg::OP_PLP, 8'h00, 16'h0000);
    queue_instr(crtu_pkg::OP_CLC, 8'h00, 16'h0000);
    queue_instr(crtu_pkg::OP_XCE, 8'h00, 16'h0000);
    queue_instr(crtu_pkg::OP_REP, 8'hFF, 16'h0000);
    queue_instr(crtu_pkg::OP_PLX, 8'h00, 16'hFFFF);
    queue_instr(crtu_pkg::OP_PLY, 8'h00, 16'h8000);
    queue_instr(crtu_pkg::OP_PLA, 8'h00, 16'h0000);
    queue_instr(crtu_pkg::OP_TAX, 8'h00, 16'h0000);
    queue_instr(crtu_pkg::OP_TYA, 8'h00, 16'h0000);
    queue_instr(crtu_pkg::OP_TAY, 8'h00, 16'h0000);
    queue_instr(crtu_pkg::OP_TXA, 8'h00, 16'h0000);
    queue_instr(crtu_pkg::OP_TYX, 8'h00, 16'h0000);
    queue_instr(crtu_pkg::OP_TXY, 8'h00, 16'h0000);
    queue_instr(crtu_pkg::OP_PHA, 8'h00, 16'h0000);
    queue_instr(crtu_pkg::OP_PHX, 8'h00, 16'h0000);
    queue_instr(crtu_pkg::OP_PHY, 8'h00, 16'h0000);
    queue_instr(crtu_pkg::OP_PHD, 8'h00, 16'h0000);
    queue_instr(crtu_pkg::OP_PHB, 8'h00, 16'h0000);
    queue_instr(crtu_pkg::OP_TCD, 8'h00, 16'h0000);
    queue_instr(crtu_pkg::OP_TCS, 8'h00, 16'h0000);
    queue_instr(crtu_pkg::OP_PHB, 8'h00, 16'h0000);
    queue_instr(crtu_pkg::OP_TSX, 8'h00, 16'h0000);
    queue_instr(crtu_pkg::OP_TXS, 8'h00, 16'h0000);
    queue_instr(crtu_pkg::OP_TDC, 8'h00, 16'h0000);
    queue_instr(crtu_pkg::OP_PLD, 8'h00, 16'hFFFF);
    queue_instr(crtu_pkg::OP_PLB, 8'h00, 16'h00FF);
    queue_instr(crtu_pkg::OP_SEP, 8'hFF, 16'h0000);
    queue_instr(crtu_pkg::OP_CLD, 8'h00, 16'h0000);
    queue_instr(crtu_pkg::OP_CLI, 8'h00, 16'h0000);
    queue_instr(crtu_pkg::OP_CLV, 8'h00, 16'h0000);
    queue_instr(crtu_pkg::OP_SED, 8'h00, 16'h0000);
    queue_instr(crtu_pkg::OP_SEI, 8'h00, 16'h0000);
    queue_instr(crtu_pkg::OP_SEC, 8'h00, 16'h0000);
    queue_instr(crtu_pkg::OP_XCE, 8'h00, 16'h0000);
    queue_instr(crtu_pkg::OP_PLA, 8'h00, 16'h0000);
    queue_instr(crtu_pkg::OP_TCS, 8'h00, 16'h0000);
    queue_instr(crtu_pkg::OP_PHD, 8'h00, 16'h0000);
    queue_instr(crtu_pkg::OP_PLB, 8'h00, 16'h0000);
    queue_instr(OP_LAST_UNUSED, 8'hFF, 16'hFFFF);
    repeat (606) pending_q.push_back(random_instr());
    total_items = pending_q.size();

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (accepted != total_items || expected_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/crtu_pkg.sv
hdl/crtu_front.sv
hdl/crtu_queue.sv
hdl/crtu_back.sv
hdl/cpu_register_transfer_unit.sv
sim/testbench.sv
